// ----- hw/rtl/pip_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_pkg: shared definitions for the point in polygon crossing test
// Widths, register codes, the command beat carried from the front part to
// the back part, and the result beat.
// ---------------------------------------------------------------------------
package pip_pkg;

   // Table size and fixed point format.
   localparam int MAX_EDGES   = 256;
   localparam int FRAC_BITS   = 16;
   localparam int EDGE_AW     = $clog2(MAX_EDGES);
   localparam int COORD_W     = 32;
   localparam int DIR_W       = 18;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int EDGE_W      = 4 * COORD_W;
   localparam int CNT_W       = 9;
   localparam int TOL_W       = 16;
   localparam int IDX_W       = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // Operation codes of an input beat.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Register indexes, taken from the word address.
   localparam logic REG_EDGE_COUNT = 1'b0;
   localparam logic REG_TOLERANCE  = 1'b1;

   // One classified beat waiting for the back part.
   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    idx;
      logic [EDGE_W-1:0]   data;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic              inside_res;
      logic              on_boundary;
      logic              degenerate;
      logic [CNT_W-1:0]  crossings;
   } result_type;

   // Clamp a difference of two coordinates back into the coordinate range.
   function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W:0] v);
      logic [COORD_W-1:0] r;
      if (v[COORD_W] != v[COORD_W-1]) begin
         r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/point_in_polygon_crossing_test_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_crossing_test_top: ray crossing containment test
// Loads fill an edge table; a query casts a ray from a point and counts the
// edges it crosses, with early stops on the boundary or on a vertex hit.
//
//   channel  ports   handshake            beat
//   input    req_*   push / full          one load or one query
//   result   rsp_*   pop / empty          one result per query
//   config   csr_*   psel/penable/pwrite  edge_count at 0x0, tolerance at 0x4
//
// A query walks the edges one by one; its time is mostly set by the serial
// divider, which makes one quotient bit a cycle for up to two quotients.
// A load is written into the edge table once it reaches the back part.
// Reset clears the control state; the edge table is not cleared.
// The input queue holds two beats, and one result waits in the output slot.
// ---------------------------------------------------------------------------
module point_in_polygon_crossing_test_top import pip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_operation,
   input  logic [IDX_W-1:0]          req_edge_index,
   input  logic signed [COORD_W-1:0] req_seg_ax,
   input  logic signed [COORD_W-1:0] req_seg_ay,
   input  logic signed [COORD_W-1:0] req_seg_bx,
   input  logic signed [COORD_W-1:0] req_seg_by,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [DIR_W-1:0]   req_dir_x,
   input  logic signed [DIR_W-1:0]   req_dir_y,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_inside_res,
   output logic                      rsp_on_boundary,
   output logic                      rsp_degenerate,
   output logic [CNT_W-1:0]          rsp_crossings,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready
);

   logic [CNT_W-1:0]  edge_count_ff, edge_count_in;
   logic [TOL_W-1:0]  tolerance_ff, tolerance_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff;
   logic              cmd_valid;
   logic              cmd_take;
   cmd_type           cmd;
   logic              result_load;
   result_type        result;
   logic              csr_write;

   pip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .operation  (req_operation),
      .edge_index (req_edge_index),
      .seg_ax     (req_seg_ax),
      .seg_ay     (req_seg_ay),
      .seg_bx     (req_seg_bx),
      .seg_by     (req_seg_by),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .dir_x      (req_dir_x),
      .dir_y      (req_dir_y),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take),
      .cmd        (cmd)
   );

   pip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd         (cmd),
      .edge_count  (edge_count_ff),
      .tolerance   (tolerance_ff),
      .result_full (rsp_valid_ff && !rsp_pop),
      .result_load (result_load),
      .result      (result)
   );

   // Register writes and reads.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      edge_count_in = edge_count_ff;
      tolerance_in  = tolerance_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EDGE_COUNT: edge_count_in = csr_pwdata[CNT_W-1:0];
            REG_TOLERANCE:  tolerance_in  = csr_pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EDGE_COUNT: csr_prdata = {{(CSR_DW-CNT_W){1'b0}}, edge_count_ff};
         REG_TOLERANCE:  csr_prdata = {{(CSR_DW-TOL_W){1'b0}}, tolerance_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Output slot.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         tolerance_ff  <= TOL_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         edge_count_ff <= edge_count_in;
         tolerance_ff  <= tolerance_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result;
      end
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_inside_res  = result_ff.inside_res;
   assign rsp_on_boundary = result_ff.on_boundary;
   assign rsp_degenerate  = result_ff.degenerate;
   assign rsp_crossings   = result_ff.crossings;

endmodule

// ----- hw/rtl/pip_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pip_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_div: serial fixed point divider
// Gives num / den with FRAC_BITS fraction bits, truncated toward zero and
// clamped to the coordinate range. One quotient bit is made each cycle.
// ---------------------------------------------------------------------------
module pip_div import pip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [PROD_W-1:0]  num,
   input  logic signed [PROD_W-1:0]  den,
   output logic                      done,
   output logic signed [COORD_W-1:0] quo
);

   localparam int STEP_W = $clog2(COORD_W);

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_PREP = 4'b0010,
      D_RUN  = 4'b0100,
      D_FIN  = 4'b1000
   } div_state_type;

   div_state_type        state_ff, state_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic                 num_neg_ff, num_neg_in;
   logic [PROD_W-1:0]    n_ff, n_in;
   logic [PROD_W-1:0]    d_ff, d_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [COORD_W-1:0]   low_ff, low_in;
   logic [COORD_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COORD_W-1:0]   quo_ff, quo_in;

   logic [PROD_W:0]      trial;
   logic [COORD_W-1:0]   lim;
   logic [COORD_W-1:0]   q_sat;

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      num_neg_in = num_neg_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      q_in       = q_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      trial      = {rem_ff, low_ff[COORD_W-1]};
      lim        = neg_ff ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      q_sat      = (q_ff > lim) ? lim : q_ff;

      unique case (state_ff)
         // Take magnitudes and the sign of the quotient.
         D_IDLE: begin
            if (start) begin
               neg_in     = num[PROD_W-1] ^ den[PROD_W-1];
               num_neg_in = num[PROD_W-1];
               n_in       = num[PROD_W-1] ? (~num + 1'b1) : num;
               d_in       = den[PROD_W-1] ? (~den + 1'b1) : den;
               state_in   = D_PREP;
            end
         end
         // Zero divisor and quotients past 32 bits clamp at once.
         D_PREP: begin
            if (d_ff == '0) begin
               quo_in   = num_neg_ff ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if ({{FRAC_BITS{1'b0}}, n_ff} >= {d_ff, {FRAC_BITS{1'b0}}}) begin
               quo_in   = lim;
               quo_in   = neg_ff ? (~lim + 1'b1) : lim;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               rem_in   = {{FRAC_BITS{1'b0}}, n_ff[PROD_W-1:FRAC_BITS]};
               low_in   = {n_ff[FRAC_BITS-1:0], {(COORD_W-FRAC_BITS){1'b0}}};
               q_in     = '0;
               step_in  = '0;
               state_in = D_RUN;
            end
         end
         // Restoring division, one bit a cycle.
         D_RUN: begin
            if (trial >= {1'b0, d_ff}) begin
               rem_in = PROD_W'(trial - {1'b0, d_ff});
               q_in   = {q_ff[COORD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[PROD_W-1:0];
               q_in   = {q_ff[COORD_W-2:0], 1'b0};
            end
            low_in  = {low_ff[COORD_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(COORD_W - 1)) begin
               state_in = D_FIN;
            end
         end
         // Clamp and apply the sign.
         D_FIN: begin
            quo_in   = neg_ff ? (~q_sat + 1'b1) : q_sat;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      num_neg_ff <= num_neg_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      q_ff       <= q_in;
      step_ff    <= step_in;
      quo_ff     <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- hw/rtl/pip_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_front: input side and command queue
// Accepts input beats, packs each by its operation and holds it in a short
// queue until the back part takes it.
// ---------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      operation,
   input  logic [IDX_W-1:0]          edge_index,
   input  logic signed [COORD_W-1:0] seg_ax,
   input  logic signed [COORD_W-1:0] seg_ay,
   input  logic signed [COORD_W-1:0] seg_bx,
   input  logic signed [COORD_W-1:0] seg_by,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [DIR_W-1:0]   dir_x,
   input  logic signed [DIR_W-1:0]   dir_y,
   output logic                      cmd_valid,
   input  logic                      cmd_take,
   output cmd_type                   cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PAD_W = EDGE_W - 2 * COORD_W - 2 * DIR_W;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                wr;
   logic                rd;
   cmd_type             beat;

   // Pack the beat: a load keeps both endpoints, a query its point and ray.
   always_comb begin
      beat.op  = op_type'(operation);
      beat.idx = edge_index;
      if (op_type'(operation) == OP_LOAD) begin
         beat.data = {seg_by, seg_bx, seg_ay, seg_ax};
      end else begin
         beat.data = {{PAD_W{1'b0}}, dir_y, dir_x, point_y, point_x};
      end
   end

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign wr        = push && !full;
   assign rd        = cmd_take && cmd_valid;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = wr ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr && !rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (rd && !wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule

// ----- hw/rtl/pip_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_back: edge table and crossing walk
// Writes loads into the edge table and, for a query, walks the edges one by
// one through a shared multiplier and a serial divider, counting crossings.
// ---------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  cmd_type           cmd,
   input  logic [CNT_W-1:0]  edge_count,
   input  logic [TOL_W-1:0]  tolerance,
   input  logic              result_full,
   output logic              result_load,
   output result_type        result
);

   typedef enum logic [7:0] {
      B_IDLE = 8'b0000_0001,
      B_READ = 8'b0000_0010,
      B_DIFF = 8'b0000_0100,
      B_MUL  = 8'b0000_1000,
      B_DEC  = 8'b0001_0000,
      B_DIVW = 8'b0010_0000,
      B_EVAL = 8'b0100_0000,
      B_DONE = 8'b1000_0000
   } back_state_type;

   typedef enum logic [3:0] {
      PH_T_MAIN = 4'b0001,
      PH_S_MAIN = 4'b0010,
      PH_U      = 4'b0100,
      PH_T_COL  = 4'b1000
   } phase_type;

   localparam int MSTEPS = 6;
   localparam int MCNT_W = $clog2(MSTEPS + 1);

   back_state_type              state_ff, state_in;
   phase_type                   phase_ff, phase_in;
   logic [CNT_W-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]            last_ff, last_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        onb_ff, onb_in;
   logic                        deg_ff, deg_in;
   logic [MCNT_W-1:0]           mcnt_ff, mcnt_in;
   logic signed [COORD_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [DIR_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic signed [COORD_W-1:0]   ex_ff, ex_in, ey_ff, ey_in;
   logic signed [COORD_W-1:0]   wx_ff, wx_in, wy_ff, wy_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in, hold_ff, hold_in;
   logic signed [PROD_W-1:0]    det_ff, det_in, nt_ff, nt_in, ns_ff, ns_in;
   logic signed [COORD_W-1:0]   t_ff, t_in, s_ff, s_in;

   logic                        ram_wr;
   logic                        ram_rd;
   logic [EDGE_W-1:0]           ram_q;
   logic                        div_start;
   logic signed [PROD_W-1:0]    div_num;
   logic signed [PROD_W-1:0]    div_den;
   logic                        div_done;
   logic signed [COORD_W-1:0]   div_quo;

   logic signed [COORD_W-1:0]   mul_a, mul_b;
   logic signed [COORD_W-1:0]   dx32, dy32, eps32;
   logic [CNT_W-1:0]            n_edges;
   logic [PROD_W-1:0]           det_mag;
   logic [COORD_W:0]            t_mag;
   logic                        s_in_range;
   logic                        t_pos;

   pip_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cmd.idx[EDGE_AW-1:0]),
      .wr_data (cmd.data),
      .rd_en   (ram_rd),
      .rd_addr (pos_ff[EDGE_AW-1:0]),
      .rd_data (ram_q)
   );

   pip_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Parameter within (-eps, 1 + eps).
   function automatic logic in_range(input logic signed [COORD_W-1:0] v,
                                     input logic [TOL_W-1:0] e);
      logic signed [COORD_W+1:0] vv;
      logic signed [COORD_W+1:0] ee;
      logic signed [COORD_W+1:0] one;
      vv  = {{2{v[COORD_W-1]}}, v};
      ee  = {{(COORD_W+2-TOL_W){1'b0}}, e};
      one = (COORD_W+2)'(1) << FRAC_BITS;
      return (vv > -ee) && (vv < one + ee);
   endfunction

   function automatic logic signed [PROD_W-1:0] widen(input logic signed [COORD_W-1:0] v);
      return {{(PROD_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   assign dx32     = {{(COORD_W-DIR_W){dx_ff[DIR_W-1]}}, dx_ff};
   assign dy32     = {{(COORD_W-DIR_W){dy_ff[DIR_W-1]}}, dy_ff};
   assign eps32    = {{(COORD_W-TOL_W){1'b0}}, tolerance};
   assign n_edges  = (edge_count > CNT_W'(MAX_EDGES)) ? CNT_W'(MAX_EDGES) : edge_count;
   assign det_mag  = det_ff[PROD_W-1] ? (~det_ff + 1'b1) : det_ff;
   assign t_mag    = t_ff[COORD_W-1] ? (~{1'b1, t_ff} + 1'b1) : {1'b0, t_ff};
   assign s_in_range = in_range(s_ff, tolerance);
   assign t_pos    = !t_ff[COORD_W-1] && (t_ff != '0);

   // Operands of the shared multiplier, one product per cycle.
   always_comb begin
      case (mcnt_ff)
         MCNT_W'(0): begin mul_a = dx32; mul_b = ey_ff; end
         MCNT_W'(1): begin mul_a = ex_ff; mul_b = dy32; end
         MCNT_W'(2): begin mul_a = ey_ff; mul_b = wx_ff; end
         MCNT_W'(3): begin mul_a = ex_ff; mul_b = wy_ff; end
         MCNT_W'(4): begin mul_a = dx32; mul_b = wy_ff; end
         default:    begin mul_a = dy32; mul_b = wx_ff; end
      endcase
   end

   // Walk sequencer.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      cnt_in     = cnt_ff;
      onb_in     = onb_ff;
      deg_in     = deg_ff;
      mcnt_in    = mcnt_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ex_in      = ex_ff;
      ey_in      = ey_ff;
      wx_in      = wx_ff;
      wy_in      = wy_ff;
      prod_in    = prod_ff;
      hold_in    = hold_ff;
      det_in     = det_ff;
      nt_in      = nt_ff;
      ns_in      = ns_ff;
      t_in       = t_ff;
      s_in       = s_ff;
      cmd_take   = 1'b0;
      ram_wr     = 1'b0;
      ram_rd     = 1'b0;
      div_start  = 1'b0;
      div_num    = nt_ff;
      div_den    = det_ff;
      result_load = 1'b0;
      result.degenerate  = deg_ff;
      result.on_boundary = onb_ff;
      result.inside_res  = onb_ff || (!deg_ff && cnt_ff[0]);
      result.crossings   = cnt_ff;

      unique case (state_ff)
         // Take the next beat: a load writes the table, a query starts a walk.
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd.op == OP_LOAD) begin
                  ram_wr = 1'b1;
               end else begin
                  px_in   = cmd.data[COORD_W-1:0];
                  py_in   = cmd.data[2*COORD_W-1:COORD_W];
                  dx_in   = cmd.data[2*COORD_W+DIR_W-1:2*COORD_W];
                  dy_in   = cmd.data[2*COORD_W+2*DIR_W-1:2*COORD_W+DIR_W];
                  pos_in  = '0;
                  cnt_in  = '0;
                  onb_in  = 1'b0;
                  deg_in  = 1'b0;
                  last_in = n_edges;
                  state_in = (n_edges == '0) ? B_DONE : B_READ;
               end
            end
         end
         B_READ: begin
            ram_rd   = 1'b1;
            state_in = B_DIFF;
         end
         // Edge vector and point to end point vector.
         B_DIFF: begin
            ex_in = sat_coord({ram_q[3*COORD_W-1], ram_q[3*COORD_W-1:2*COORD_W]}
                              - {ram_q[COORD_W-1], ram_q[COORD_W-1:0]});
            ey_in = sat_coord({ram_q[4*COORD_W-1], ram_q[4*COORD_W-1:3*COORD_W]}
                              - {ram_q[2*COORD_W-1], ram_q[2*COORD_W-1:COORD_W]});
            wx_in = sat_coord({ram_q[3*COORD_W-1], ram_q[3*COORD_W-1:2*COORD_W]}
                              - {px_ff[COORD_W-1], px_ff});
            wy_in = sat_coord({ram_q[4*COORD_W-1], ram_q[4*COORD_W-1:3*COORD_W]}
                              - {py_ff[COORD_W-1], py_ff});
            mcnt_in  = '0;
            state_in = B_MUL;
         end
         // Determinant and both numerators, from pairs of products.
         B_MUL: begin
            prod_in = mul_a * mul_b;
            case (mcnt_ff) inside
               MCNT_W'(1), MCNT_W'(3), MCNT_W'(5): hold_in = prod_ff;
               MCNT_W'(2): det_in = hold_ff - prod_ff;
               MCNT_W'(4): nt_in  = hold_ff - prod_ff;
               MCNT_W'(6): ns_in  = hold_ff - prod_ff;
               default: ;
            endcase
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MCNT_W'(MSTEPS)) begin
               state_in = B_DEC;
            end
         end
         // Crossing lines, or the collinear branch.
         B_DEC: begin
            div_start = 1'b1;
            if (det_mag > (PROD_W'(tolerance) << FRAC_BITS)) begin
               div_num  = nt_ff;
               div_den  = det_ff;
               phase_in = PH_T_MAIN;
            end else begin
               div_num  = (ex_ff > eps32) ? widen(wx_ff) : widen(wy_ff);
               div_den  = (ex_ff > eps32) ? widen(ex_ff) : widen(ey_ff);
               phase_in = PH_U;
            end
            state_in = B_DIVW;
         end
         B_DIVW: begin
            if (div_done) begin
               unique case (phase_ff)
                  PH_T_MAIN: begin
                     t_in      = div_quo;
                     div_start = 1'b1;
                     div_num   = ns_ff;
                     div_den   = det_ff;
                     phase_in  = PH_S_MAIN;
                  end
                  PH_S_MAIN: begin
                     s_in     = div_quo;
                     state_in = B_EVAL;
                  end
                  PH_U: begin
                     if (in_range(div_quo, tolerance)) begin
                        t_in     = '0;
                        s_in     = div_quo;
                        state_in = B_EVAL;
                     end else begin
                        div_start = 1'b1;
                        div_num   = (dx32 > eps32) ? widen(wx_ff) : widen(wy_ff);
                        div_den   = (dx32 > eps32) ? widen(dx32) : widen(dy32);
                        phase_in  = PH_T_COL;
                     end
                  end
                  PH_T_COL: begin
                     t_in     = div_quo;
                     s_in     = '0;
                     state_in = B_EVAL;
                  end
                  default: begin
                     state_in = B_EVAL;
                  end
               endcase
            end
         end
         // Classify the hit, then stop or move to the next edge.
         B_EVAL: begin
            if (s_ff == '0 && t_pos) begin
               deg_in   = 1'b1;
               state_in = B_DONE;
            end else if (s_in_range && t_mag <= {{(COORD_W+1-TOL_W){1'b0}}, tolerance}) begin
               onb_in   = 1'b1;
               state_in = B_DONE;
            end else begin
               if (s_in_range && t_pos) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (pos_ff + 1'b1 == last_ff) begin
                  state_in = B_DONE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = B_READ;
               end
            end
         end
         // Hand the result to the output slot.
         B_DONE: begin
            if (!result_full) begin
               result_load = 1'b1;
               state_in    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         onb_ff   <= 1'b0;
         deg_ff   <= 1'b0;
         last_ff  <= '0;
         mcnt_ff  <= '0;
         phase_ff <= PH_T_MAIN;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         onb_ff   <= onb_in;
         deg_ff   <= deg_in;
         last_ff  <= last_in;
         mcnt_ff  <= mcnt_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      det_ff  <= det_in;
      nt_ff   <= nt_in;
      ns_ff   <= ns_in;
      t_ff    <= t_in;
      s_ff    <= s_in;
   end

endmodule

// ----- hw/rtl/pip_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pip_checker: port level checks
// Watches the result channel and the register port of the top level.
// ---------------------------------------------------------------------------
module pip_checker import pip_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic              rsp_inside_res,
   input  logic              rsp_on_boundary,
   input  logic              rsp_degenerate,
   input  logic [CNT_W-1:0]  rsp_crossings,
   input  logic              csr_pready
);

   // A waiting result stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_crossings)
                                    && $stable(rsp_inside_res)))
      else $error("result changed while stalled");

   // A boundary hit always reports inside, and never together with a retry.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_on_boundary) |-> (rsp_inside_res && !rsp_degenerate))
      else $error("boundary result inconsistent");

   // A retry result never reports inside.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |-> !rsp_inside_res)
      else $error("retry result reports inside");

   // A full walk reports the parity of its crossings.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_degenerate && !rsp_on_boundary)
         |-> (rsp_inside_res == rsp_crossings[0]))
      else $error("inside flag disagrees with crossing parity");

   // The register port never waits.
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind point_in_polygon_crossing_test_top pip_checker u_pip_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: point in polygon crossing test bench
// Loads polygon edges into the block, casts rays from query points and checks
// every result beat against a fixed point predictor of the crossing walk,
// under several idle and stall patterns and register settings.
// ---------------------------------------------------------------------------
module tb;
   import pip_pkg::*;

   localparam longint UNIT       = 64'sd65536;
   localparam int     CYCLE_CAP  = 2_000_000;
   localparam int     LONG_WALK  = 32;

   // One input beat as the bench sees it.
   typedef struct {
      op_type                    op;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
      logic signed [DIR_W-1:0]   dx, dy;
   } pip_beat_type;

   // Containment predictor and the queue of results it still waits for.
   class containment_scoreboard;
      longint     start_x[MAX_EDGES], start_y[MAX_EDGES];
      longint     end_x[MAX_EDGES], end_y[MAX_EDGES];
      bit         loaded[MAX_EDGES];
      int         walk_len;
      longint     eps;
      result_type awaited[$];
      int         errors;
      int         queries;
      int         loads;

      function new();
         walk_len = 0;
         eps = 1;
         errors = 0;
      endfunction

      function int loaded_prefix();
         int k;
         k = 0;
         while (k < MAX_EDGES && loaded[k]) k++;
         return k;
      endfunction

      function void set_register(int idx, int value);
         if (idx == 0) walk_len = value & 'h1FF;
         else eps = value & 'hFFFF;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Fixed point quotient, truncated toward zero and saturated.
      function longint fx_div(longint num, longint den);
         bit neg;
         longint unsigned n, d, lim, qi, r, q;
         neg = (num < 0) != (den < 0);
         n = num < 0 ? -num : num;
         d = den < 0 ? -den : den;
         if (d == 0) return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
         lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         qi = n / d;
         r = n % d;
         if (qi > (lim >> FRAC_BITS)) q = lim;
         else begin
            q = qi;
            for (int i = 0; i < FRAC_BITS; i++) begin
               r = r << 1;
               q = q << 1;
               if (r >= d) begin
                  r = r - d;
                  q = q | 1;
               end
            end
            if (q > lim) q = lim;
         end
         return neg ? -longint'(q) : longint'(q);
      endfunction

      // Ray against one segment: ray parameter and segment parameter.
      function void ray_vs_segment(longint px, longint py, longint dx, longint dy,
                                   int k, output longint t, output longint s);
         longint ex, ey, wx, wy, det, u;
         longint unsigned mag;
         ex = clamp32(end_x[k] - start_x[k]);
         ey = clamp32(end_y[k] - start_y[k]);
         wx = clamp32(end_x[k] - px);
         wy = clamp32(end_y[k] - py);
         det = dx * ey - ex * dy;
         mag = det < 0 ? -det : det;
         if (mag > (longint'(eps) << FRAC_BITS)) begin
            t = fx_div(ey * wx - ex * wy, det);
            s = fx_div(dx * wy - dy * wx, det);
            return;
         end
         // Parallel or collinear: try the point on the segment line first.
         u = (ex > eps) ? fx_div(wx, ex) : fx_div(wy, ey);
         if (-eps < u && u < UNIT + eps) begin
            t = 0;
            s = u;
            return;
         end
         t = (dx > eps) ? fx_div(wx, dx) : fx_div(wy, dy);
         s = 0;
      endfunction

      function void note_beat(pip_beat_type b);
         result_type res;
         longint t, s, at;
         int n, tally;
         if (b.op == OP_LOAD) begin
            start_x[b.idx] = b.ax;
            start_y[b.idx] = b.ay;
            end_x[b.idx] = b.bx;
            end_y[b.idx] = b.by;
            loaded[b.idx] = 1;
            loads++;
            return;
         end
         queries++;
         res = '0;
         tally = 0;
         n = walk_len > MAX_EDGES ? MAX_EDGES : walk_len;
         for (int k = 0; k < n; k++) begin
            ray_vs_segment(b.px, b.py, b.dx, b.dy, k, t, s);
            if (s == 0 && t > 0) begin
               res.degenerate = 1;
               break;
            end
            if (-eps < s && s < UNIT + eps) begin
               at = t < 0 ? -t : t;
               if (at <= eps) begin
                  res.inside_res = 1;
                  res.on_boundary = 1;
                  break;
               end
               if (t > 0) tally++;
            end
         end
         if (!res.degenerate && !res.on_boundary) res.inside_res = tally[0];
         res.crossings = CNT_W'(tally > 511 ? 511 : tally);
         awaited = {awaited, res};
      endfunction

      function void check_result(result_type got);
         result_type exp_res;
         if (awaited.size() == 0) begin
            errors++;
            $error("result beat with no query waiting for it");
            return;
         end
         exp_res = awaited.pop_front();
         if (got.inside_res !== exp_res.inside_res) begin
            errors++;
            $error("inside_res: expected %0d, got %0d", exp_res.inside_res, got.inside_res);
         end
         if (got.on_boundary !== exp_res.on_boundary) begin
            errors++;
            $error("on_boundary: expected %0d, got %0d", exp_res.on_boundary,
                   got.on_boundary);
         end
         if (got.degenerate !== exp_res.degenerate) begin
            errors++;
            $error("degenerate: expected %0d, got %0d", exp_res.degenerate, got.degenerate);
         end
         if (got.crossings !== exp_res.crossings) begin
            errors++;
            $error("crossings: expected %0d, got %0d", exp_res.crossings, got.crossings);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic                      req_operation;
   logic [IDX_W-1:0]          req_edge_index;
   logic signed [COORD_W-1:0] req_seg_ax, req_seg_ay, req_seg_bx, req_seg_by;
   logic signed [COORD_W-1:0] req_point_x, req_point_y;
   logic signed [DIR_W-1:0]   req_dir_x, req_dir_y;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic                      rsp_inside_res, rsp_on_boundary, rsp_degenerate;
   logic [CNT_W-1:0]          rsp_crossings;
   logic                      csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0]         csr_paddr;
   logic [CSR_DW-1:0]         csr_pwdata;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   containment_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   bit  hold_taken;
   int  hold_left;
   bit  saw_full;
   int  cycle_count;
   int  hits_degenerate, hits_boundary;

   point_in_polygon_crossing_test_top u_top (.*);

   // Clock and cycle budget.
   initial clock = 0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[point_in_polygon_crossing_test_top] ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1;
         hold_left = 3000;
         rsp_pop <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result beats are checked mid-cycle, where pop and empty are settled.
   always @(negedge clock) begin
      if (!reset && req_push && req_full) saw_full = 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rsp_degenerate) hits_degenerate++;
         if (rsp_on_boundary) hits_boundary++;
         sb.check_result('{rsp_inside_res, rsp_on_boundary, rsp_degenerate,
                           rsp_crossings});
      end
   end

   task automatic send_beat(pip_beat_type b);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push       <= 1;
      req_operation  <= b.op;
      req_edge_index <= b.idx;
      req_seg_ax     <= b.ax;
      req_seg_ay     <= b.ay;
      req_seg_bx     <= b.bx;
      req_seg_by     <= b.by;
      req_point_x    <= b.px;
      req_point_y    <= b.py;
      req_dir_x      <= b.dx;
      req_dir_y      <= b.dy;
      do begin
         @(negedge clock);
         stalled = req_full;
         @(posedge clock);
      end while (stalled);
      sb.note_beat(b);
   endtask

   // Waits until no result is outstanding and the back part has gone quiet.
   task automatic drain();
      req_push <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_register(int idx, int value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CSR_AW'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      sb.set_register(idx, value);
   endtask

   function automatic pip_beat_type load_beat(int idx, longint ax, longint ay,
                                              longint bx, longint by);
      pip_beat_type b;
      b.op = OP_LOAD;
      b.idx = IDX_W'(idx);
      b.ax = COORD_W'(ax);
      b.ay = COORD_W'(ay);
      b.bx = COORD_W'(bx);
      b.by = COORD_W'(by);
      b.px = '0;
      b.py = '0;
      b.dx = '0;
      b.dy = '0;
      return b;
   endfunction

   function automatic pip_beat_type query_beat(longint px, longint py, longint dx,
                                               longint dy);
      pip_beat_type b;
      b.op = OP_QUERY;
      b.idx = '0;
      b.ax = '0;
      b.ay = '0;
      b.bx = '0;
      b.by = '0;
      b.px = COORD_W'(px);
      b.py = COORD_W'(py);
      b.dx = DIR_W'(dx);
      b.dy = DIR_W'(dy);
      return b;
   endfunction

   // Coordinates: mostly on a unit grid near the origin, some near it, a few wild.
   function automatic longint pick_coord();
      int r;
      r = $urandom_range(99);
      if (r < 65) return (longint'($urandom_range(12)) - 6) * UNIT;
      if (r < 90) return longint'($urandom_range(786432)) - 393216;
      return longint'(int'($urandom));
   endfunction

   function automatic pip_beat_type random_query();
      longint dx, dy;
      case ($urandom_range(9))
         0: begin dx = UNIT;   dy = 0; end
         1: begin dx = -UNIT;  dy = 0; end
         2: begin dx = 0;      dy = UNIT; end
         3: begin dx = 0;      dy = -UNIT; end
         4: begin dx = 46341;  dy = 46341; end
         5: begin dx = -46341; dy = 46341; end
         6: begin dx = 39322;  dy = -52429; end
         default: begin
            dx = longint'($urandom);
            dy = longint'($urandom);
         end
      endcase
      return query_beat(pick_coord(), pick_coord(), dx, dy);
   endfunction

   task automatic random_phase(int beats, int walk_cap);
      int prefix, slot;
      for (int i = 0; i < beats; i++) begin
         prefix = sb.loaded_prefix();
         if ($urandom_range(99) < 35) begin
            // Loads reshape the walked polygon or extend the loaded run.
            if ($urandom_range(9) == 0) slot = $urandom_range(MAX_EDGES - 1);
            else slot = $urandom_range(prefix < walk_cap ? prefix : walk_cap - 1);
            send_beat(load_beat(slot, pick_coord(), pick_coord(),
                                pick_coord(), pick_coord()));
         end else begin
            send_beat(random_query());
         end
      end
   endtask

   initial begin
      int mode_idle[4]  = '{0, 85, 0, 34};
      int mode_stall[4] = '{0, 0, 85, 34};
      int tol_set[4]    = '{0, 65535, 1, 300};
      int walk;
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      reset = 1;
      req_push = 0;
      req_operation = OP_LOAD;
      req_edge_index = 0;
      {req_seg_ax, req_seg_ay, req_seg_bx, req_seg_by} = '0;
      {req_point_x, req_point_y, req_dir_x, req_dir_y} = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: a 4 by 4 square and the corner cases around it.
      send_beat(load_beat(0, 0, 0, 4 * UNIT, 0));
      send_beat(load_beat(1, 4 * UNIT, 0, 4 * UNIT, 4 * UNIT));
      send_beat(load_beat(2, 4 * UNIT, 4 * UNIT, 0, 4 * UNIT));
      send_beat(load_beat(3, 0, 4 * UNIT, 0, 0));
      send_beat(load_beat(255, 64'sd2147483647, -64'sd2147483648,
                          -64'sd2147483648, 64'sd2147483647));
      send_beat(query_beat(UNIT, UNIT, UNIT, 0));
      drain();
      write_register(0, 4);
      write_register(1, 1);
      send_beat(query_beat(2 * UNIT, 2 * UNIT, UNIT, 0));
      send_beat(query_beat(6 * UNIT, 2 * UNIT, UNIT, 0));
      send_beat(query_beat(4 * UNIT, 2 * UNIT, UNIT, 0));
      send_beat(query_beat(4 * UNIT, -2 * UNIT, 0, UNIT));
      send_beat(query_beat(-2 * UNIT, 4 * UNIT, UNIT, 0));
      send_beat(query_beat(-2 * UNIT, -2 * UNIT, 46341, 46341));
      send_beat(query_beat(64'sd2147483647, -64'sd2147483648, -UNIT, UNIT));
      send_beat(query_beat(-64'sd2147483648, 64'sd2147483647, -131072, 131071));
      send_beat(query_beat(UNIT, 3 * UNIT, 0, -UNIT));
      send_beat(query_beat(2 * UNIT, 2 * UNIT, 0, 0));
      drain();
      write_register(0, 0);
      send_beat(query_beat(2 * UNIT, 2 * UNIT, UNIT, 0));
      drain();

      // Random part: one idle pattern per phase, new registers each time.
      for (int p = 0; p < 4; p++) begin
         walk = $urandom_range(1, sb.loaded_prefix() < 12 ? sb.loaded_prefix() : 12);
         write_register(0, walk);
         write_register(1, tol_set[p]);
         send_idle_pct = mode_idle[p];
         recv_stall_pct = mode_stall[p];
         if (p == 1) hold_request = 1;
         random_phase(26, 12);
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      // Longer walks: extend the loaded run, then walk all of it.
      write_register(1, 1);
      for (int k = sb.loaded_prefix(); k < LONG_WALK; k++) begin
         send_beat(load_beat(k, pick_coord(), pick_coord(), pick_coord(), pick_coord()));
      end
      drain();
      write_register(0, LONG_WALK);
      send_beat(random_query());
      send_beat(query_beat(UNIT / 2, UNIT / 2, UNIT, 0));
      drain();

      $display("Checked %0d queries and %0d loads; %0d boundary and %0d retry results.",
               sb.queries, sb.loads, hits_boundary, hits_degenerate);
      $display("Input back-pressure seen: %0d; walks of 0, 4, random and %0d edges.",
               saw_full, LONG_WALK);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("[point_in_polygon_crossing_test_top] OK");
      end else begin
         $display("[point_in_polygon_crossing_test_top] ERROR");
      end
      $finish;
   end

endmodule
